@@ hdl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Types, widths, register indexes and helpers shared by the barometric
// pressure compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

   localparam int RAW_W     = 24;
   localparam int COEF_W    = 16;
   localparam int IDX_W     = 3;
   localparam int DT_W      = 25;
   localparam int MUL_W     = 42;
   localparam int Q_W       = 19;
   localparam int SQ1_W     = 2 * Q_W;
   localparam int SQ2_W     = 2 * (Q_W + 1);
   localparam int TERM_W    = 41;
   localparam int OFF_W     = 41;
   localparam int SENS_W    = 40;
   localparam int SENS_LO_W = 20;
   localparam int PL_W      = RAW_W + SENS_LO_W;
   localparam int PH_W      = RAW_W + 1 + SENS_W - SENS_LO_W;
   localparam int PROD_W    = 64;
   localparam int X_W       = 45;
   localparam int P_W       = 32;

   // scaling shifts of the compensation formula
   localparam int TEMP_SHIFT   = 23;
   localparam int REF_SHIFT    = 8;
   localparam int OFF_C_SHIFT  = 16;
   localparam int OFF_T_SHIFT  = 7;
   localparam int SENS_C_SHIFT = 15;
   localparam int SENS_T_SHIFT = 8;
   localparam int PROD_SHIFT   = 21;
   localparam int P_SHIFT      = 15;

   // temperature thresholds in 0.01 C, taken relative to the reference
   localparam int TEMP_REF = 2000;
   localparam int TEMP_LOW = -1500;
   localparam int Q_LOW    = TEMP_LOW - TEMP_REF;

   localparam int FRONT_STAGES = 3;
   localparam int CORR_STAGES  = 3;
   localparam int BACK_STAGES  = 4;
   localparam int PIPE_DEPTH   = FRONT_STAGES + CORR_STAGES + BACK_STAGES;

   typedef enum logic [IDX_W-1:0] {
      REG_SENS         = 3'd0,
      REG_OFFSET       = 3'd1,
      REG_SENS_TEMP    = 3'd2,
      REG_OFFSET_TEMP  = 3'd3,
      REG_REF_TEMP     = 3'd4,
      REG_TEMP_SLOPE   = 3'd5,
      REG_SECOND_ORDER = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] sens_coeff;
      logic [COEF_W-1:0] offset_coeff;
      logic [COEF_W-1:0] sens_temp_coeff;
      logic [COEF_W-1:0] offset_temp_coeff;
      logic [COEF_W-1:0] ref_temp_coeff;
      logic [COEF_W-1:0] temp_slope_coeff;
      logic              second_order_on;
   } cfg_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [Q_W-1:0]    q;
      logic signed [OFF_W-1:0]  off1;
      logic signed [SENS_W-1:0] sens1;
   } front_word_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
   } corr_word_type;

   // signed divide by 2**shift, truncating toward zero
   function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] v,
                                                    input int unsigned shift);
      logic signed [63:0] bias;
      bias = v[63] ? ((64'sd1 <<< shift) - 64'sd1) : 64'sd0;
      return (v + bias) >>> shift;
   endfunction

endpackage

`default_nettype wire

@@ hdl/bpc_channels.sv @@
// ----------------------------------------------------------------------------
// bpc channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_req_if;
   import bpc_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_pressure;
   logic [RAW_W-1:0] raw_temperature;
   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpc_rsp_if;
   import bpc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic signed [P_W-1:0] pressure;
   modport source (output valid, output pressure, input ready);
   modport sink   (input valid, input pressure, output ready);
endinterface

interface bpc_csr_if;
   import bpc_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  index;
   logic [COEF_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/bpc_front.sv @@
// ----------------------------------------------------------------------------
// bpc_front
// Temperature difference, its three coefficient products, and the first
// order offset, sensitivity and temperature term.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bpc_pkg::cfg_type         cfg,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [bpc_pkg::RAW_W-1:0] in_d1,
   input  wire logic [bpc_pkg::RAW_W-1:0] in_d2,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output bpc_pkg::front_word_type       out_word
);
   import bpc_pkg::*;

   logic [FRONT_STAGES-1:0] v_ff, v_in, en;

   logic [RAW_W-1:0]         d1_s1_ff, d1_s2_ff;
   logic signed [DT_W-1:0]   dt_ff, dt_in;
   logic signed [MUL_W-1:0]  m6_ff, m6_in, m4_ff, m4_in, m3_ff, m3_in;
   front_word_type           word_ff, word_in;

   always_comb begin
      en[FRONT_STAGES-1] = !v_ff[FRONT_STAGES-1] || out_ready;
      for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      for (int k = 0; k < FRONT_STAGES; k++) begin
         if (en[k]) begin
            v_in[k] = (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_comb begin
      dt_in = signed'({1'b0, in_d2}) - signed'({1'b0, cfg.ref_temp_coeff, {REF_SHIFT{1'b0}}});
      m6_in = dt_ff * signed'({1'b0, cfg.temp_slope_coeff});
      m4_in = dt_ff * signed'({1'b0, cfg.offset_temp_coeff});
      m3_in = dt_ff * signed'({1'b0, cfg.sens_temp_coeff});
      word_in.d1    = d1_s2_ff;
      word_in.q     = Q_W'(sdiv_pow2(64'(m6_ff), TEMP_SHIFT));
      word_in.off1  = signed'({{(OFF_W - COEF_W - OFF_C_SHIFT){1'b0}},
                               cfg.offset_coeff, {OFF_C_SHIFT{1'b0}}})
                      + OFF_W'(sdiv_pow2(64'(m4_ff), OFF_T_SHIFT));
      word_in.sens1 = signed'({{(SENS_W - COEF_W - SENS_C_SHIFT){1'b0}},
                               cfg.sens_coeff, {SENS_C_SHIFT{1'b0}}})
                      + SENS_W'(sdiv_pow2(64'(m3_ff), SENS_T_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d1_s1_ff <= in_d1;
         dt_ff    <= dt_in;
      end
      if (en[1]) begin
         d1_s2_ff <= d1_s1_ff;
         m6_ff    <= m6_in;
         m4_ff    <= m4_in;
         m3_ff    <= m3_in;
      end
      if (en[2]) begin
         word_ff <= word_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[FRONT_STAGES-1];
   assign out_word  = word_ff;

endmodule

`default_nettype wire

@@ hdl/bpc_corr.sv @@
// ----------------------------------------------------------------------------
// bpc_corr
// Low-temperature second order correction of offset and sensitivity.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_corr (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    second_order_on,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire bpc_pkg::front_word_type in_word,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output bpc_pkg::corr_word_type       out_word
);
   import bpc_pkg::*;

   logic [CORR_STAGES-1:0] v_ff, v_in, en;

   front_word_type           f1_ff, f2_ff;
   logic signed [Q_W:0]      qs;
   logic signed [SQ1_W-1:0]  sq1_ff, sq1_in;
   logic signed [SQ2_W-1:0]  sq2_ff, sq2_in;
   logic                     neg1_ff, neg1_in, neg2_ff, neg2_in;
   logic signed [TERM_W-1:0] sqa, sqb, five, seven, eleven;
   logic signed [TERM_W-1:0] t_oa_ff, t_oa_in, t_ob_ff, t_ob_in;
   logic signed [TERM_W-1:0] t_sa_ff, t_sa_in, t_sb_ff, t_sb_in;
   corr_word_type            word_ff, word_in;

   always_comb begin
      en[CORR_STAGES-1] = !v_ff[CORR_STAGES-1] || out_ready;
      for (int k = CORR_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      for (int k = 0; k < CORR_STAGES; k++) begin
         if (en[k]) begin
            v_in[k] = (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_comb begin
      // squares of (temp - 2000) and (temp + 1500)
      qs      = {in_word.q[Q_W-1], in_word.q} + (Q_W + 1)'(-Q_LOW);
      sq1_in  = in_word.q * in_word.q;
      sq2_in  = qs * qs;
      neg1_in = second_order_on && in_word.q[Q_W-1];
      neg2_in = second_order_on && (in_word.q < Q_W'(Q_LOW));

      sqa     = TERM_W'(sq1_ff);
      sqb     = TERM_W'(sq2_ff);
      five    = (sqa <<< 2) + sqa;
      seven   = (sqb <<< 3) - sqb;
      eleven  = (sqb <<< 3) + (sqb <<< 1) + sqb;
      t_oa_in = neg1_ff ? TERM_W'(sdiv_pow2(64'(five), 1)) : '0;
      t_sa_in = neg1_ff ? TERM_W'(sdiv_pow2(64'(five), 2)) : '0;
      t_ob_in = neg2_ff ? seven : '0;
      t_sb_in = neg2_ff ? TERM_W'(sdiv_pow2(64'(eleven), 1)) : '0;

      word_in.d1   = f2_ff.d1;
      word_in.off  = f2_ff.off1 - OFF_W'(t_oa_ff + t_ob_ff);
      word_in.sens = f2_ff.sens1 - SENS_W'(t_sa_ff + t_sb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         f1_ff   <= in_word;
         sq1_ff  <= sq1_in;
         sq2_ff  <= sq2_in;
         neg1_ff <= neg1_in;
         neg2_ff <= neg2_in;
      end
      if (en[1]) begin
         f2_ff   <= f1_ff;
         t_oa_ff <= t_oa_in;
         t_ob_ff <= t_ob_in;
         t_sa_ff <= t_sa_in;
         t_sb_ff <= t_sb_in;
      end
      if (en[2]) begin
         word_ff <= word_in;
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[CORR_STAGES-1];
   assign out_word  = word_ff;

endmodule

`default_nettype wire

@@ hdl/bpc_back.sv @@
// ----------------------------------------------------------------------------
// bpc_back
// Raw pressure times sensitivity in two partial products, then offset
// removal and final scaling; the last stage is the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire bpc_pkg::corr_word_type  in_word,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic signed [bpc_pkg::P_W-1:0] out_pressure
);
   import bpc_pkg::*;

   logic [BACK_STAGES-1:0] v_ff, v_in, en;

   logic [PL_W-1:0]          pl_ff, pl_in;
   logic signed [PH_W-1:0]   ph_ff, ph_in;
   logic signed [OFF_W-1:0]  off_s7_ff, off_s8_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic signed [P_W-1:0]    p_ff, p_in;

   always_comb begin
      en[BACK_STAGES-1] = !v_ff[BACK_STAGES-1] || out_ready;
      for (int k = BACK_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      for (int k = 0; k < BACK_STAGES; k++) begin
         if (en[k]) begin
            v_in[k] = (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_comb begin
      pl_in   = in_word.d1 * in_word.sens[SENS_LO_W-1:0];
      ph_in   = signed'({1'b0, in_word.d1}) * signed'(in_word.sens[SENS_W-1:SENS_LO_W]);
      prod_in = (PROD_W'(ph_ff) <<< SENS_LO_W) + signed'(PROD_W'(pl_ff));
      x_in    = X_W'(sdiv_pow2(prod_ff, PROD_SHIFT)) - X_W'(off_s8_ff);
      // result keeps the low word of the quotient
      p_in    = P_W'(sdiv_pow2(64'(x_ff), P_SHIFT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pl_ff     <= pl_in;
         ph_ff     <= ph_in;
         off_s7_ff <= in_word.off;
      end
      if (en[1]) begin
         prod_ff   <= prod_in;
         off_s8_ff <= off_s7_ff;
      end
      if (en[2]) begin
         x_ff <= x_in;
      end
      if (en[3]) begin
         p_ff <= p_in;
      end
   end

   assign in_ready     = en[0];
   assign out_valid    = v_ff[BACK_STAGES-1];
   assign out_pressure = p_ff;

endmodule

`default_nettype wire

@@ hdl/baro_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// baro_pressure_compensation
// Second order compensated pressure from raw pressure and temperature words.
// ----------------------------------------------------------------------------
// One raw pressure/temperature word goes in per cycle while the pipeline
// is not stalled. Its compensated pressure word (0.01 mbar, two's complement,
// low 32 bits) leaves through the result register of the last stage.
// The pipeline is ten register stages, two of them spent on the 24 x 40 bit
// pressure-times-sensitivity product, which is split into two partial
// products and a combining add. Every stage holds its word on a stall and
// bubbles close up, so input is taken while a result waits until all ten
// stages are full. The six calibration words and the second order enable
// are written through the csr channel, which is always ready; write them
// only while no word is in flight.
// Reset gives zero calibration words with the second order correction on.
`default_nettype none

module baro_pressure_compensation (
   input  wire logic  clock,
   input  wire logic  reset,
   bpc_req_if.sink    req_bus,
   bpc_rsp_if.source  rsp_bus,
   bpc_csr_if.sink    csr_bus
);
   import bpc_pkg::*;

   localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

   cfg_type        cfg_ff, cfg_in;
   logic           front_valid, front_ready, corr_valid, corr_ready;
   front_word_type front_word;
   corr_word_type  corr_word;
   logic [CNT_W-1:0] in_flight_ff, in_flight_in;
   logic           req_fire, rsp_fire;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (reg_index_type'(csr_bus.index))
            REG_SENS:         cfg_in.sens_coeff        = csr_bus.data;
            REG_OFFSET:       cfg_in.offset_coeff      = csr_bus.data;
            REG_SENS_TEMP:    cfg_in.sens_temp_coeff   = csr_bus.data;
            REG_OFFSET_TEMP:  cfg_in.offset_temp_coeff = csr_bus.data;
            REG_REF_TEMP:     cfg_in.ref_temp_coeff    = csr_bus.data;
            REG_TEMP_SLOPE:   cfg_in.temp_slope_coeff  = csr_bus.data;
            REG_SECOND_ORDER: cfg_in.second_order_on   = csr_bus.data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{second_order_on: 1'b1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_bus.ready = 1'b1;

   bpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_d1     (req_bus.raw_pressure),
      .in_d2     (req_bus.raw_temperature),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_word  (front_word)
   );

   bpc_corr u_corr (
      .clock           (clock),
      .reset           (reset),
      .second_order_on (cfg_ff.second_order_on),
      .in_valid        (front_valid),
      .in_ready        (front_ready),
      .in_word         (front_word),
      .out_valid       (corr_valid),
      .out_ready       (corr_ready),
      .out_word        (corr_word)
   );

   bpc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (corr_valid),
      .in_ready     (corr_ready),
      .in_word      (corr_word),
      .out_valid    (rsp_bus.valid),
      .out_ready    (rsp_bus.ready),
      .out_pressure (rsp_bus.pressure)
   );

   // words accepted but not yet delivered
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      in_flight_in = in_flight_ff + CNT_W'(req_fire) - CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid && in_flight_ff == '0)
      else $error("pipeline not empty after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> in_flight_ff != '0)
      else $error("result presented with no word in flight");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more words in flight than pipeline stages");

endmodule

`default_nettype wire
